// ===== rtl/core/imhq_pkg.sv =====
`default_nettype none
package imhq_pkg;
  localparam int unsigned MaxIdsDefault = 1024;
  localparam int unsigned KeyW = 32;
  localparam int unsigned TolW = 31;
  localparam int unsigned CfgW = 31;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_UPDATE = 3'd1,
    KIND_POP    = 3'd2,
    KIND_REMOVE = 3'd3,
    KIND_PEEK   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_ID    = 3'd2,
    ST_POS   = 3'd3,
    ST_FULL  = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    REG_TOL    = 1'b0,
    REG_ACTIVE = 1'b1
  } reg_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [9:0]  item_id;
    logic signed [31:0] key;
    logic [9:0]  position;
  } cmd_t;

  typedef struct packed {
    logic [9:0]  result_id;
    logic signed [31:0] result_key;
    logic [10:0] heap_size;
    logic [2:0]  status;
  } res_t;
endpackage
`default_nettype wire

// ===== rtl/core/imhq_front.sv =====
`default_nettype none
module imhq_front import imhq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      avail_o,
  output cmd_t      cmd_o
);
  cmd_t buf_q [2];
  logic [1:0] cnt_q;
  logic       wp_q, rp_q;

  assign full_o  = cnt_q == 2'd2;
  assign avail_o = cnt_q != 2'd0;
  assign cmd_o   = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/imhq_back.sv =====
`default_nettype none
module imhq_back import imhq_pkg::*; #(
  parameter int unsigned MaxIds = MaxIdsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic [TolW-1:0] tol_i,
  input  wire logic [10:0] active_i,
  input  wire logic avail_i,
  input  wire cmd_t cmd_i,
  output logic      pop_o,
  output logic      clr_busy_o,
  output logic      done_o,
  output res_t      res_o
);
  localparam int unsigned PW = $clog2(MaxIds);
  localparam int unsigned CW = PW + 1;

  typedef enum logic [12:0] {
    S_CLR   = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_DEC   = 13'b0000000000100,
    S_TAKE  = 13'b0000000001000,
    S_TAKE2 = 13'b0000000010000,
    S_UPRD  = 13'b0000000100000,
    S_UPK   = 13'b0000001000000,
    S_UPCMP = 13'b0000010000000,
    S_DNRD  = 13'b0000100000000,
    S_DNK   = 13'b0001000000000,
    S_DNCMP = 13'b0010000000000,
    S_OUT   = 13'b0100000000000,
    S_KEYRD = 13'b1000000000000
  } state_e;

  state_e st_q;
  logic [PW-1:0] slots [MaxIds];
  logic [KeyW-1:0] keys [MaxIds];
  logic [PW:0] bptr [MaxIds];
  logic [CW-1:0] cnt_q;
  logic [PW-1:0] clr_q;
  cmd_t c_q;
  logic [PW:0] bp_rd;
  logic [PW-1:0] sa_rd, sb_rd;
  logic [KeyW-1:0] ka_rd, kb_rd;
  logic [KeyW-1:0] mkey_q;
  logic [PW-1:0] pos_q, par_q, lft_q;
  logic [PW-1:0] ida_q, idb_q, idc_q;
  logic [PW-1:0] rid_q;
  logic [2:0] stat_q;
  logic got_q, updn_q;
  logic [PW:0] limit;
  logic signed [KeyW:0] d_ab, d_ma, d_mb;
  logic signed [KeyW:0] tol_s;

  logic          bw_en;  logic [PW-1:0] bw_a; logic [PW:0] bw_d;
  logic          bw2_en; logic [PW-1:0] bw2_a; logic [PW:0] bw2_d;
  logic          sw_en;  logic [PW-1:0] sw_a, sw_d;
  logic          sw2_en; logic [PW-1:0] sw2_a, sw2_d;
  logic          kw_en;  logic [PW-1:0] kw_a;
  logic [PW-1:0] sra, srb, bra, kra, krb;

  assign limit = (active_i < 11'(MaxIds)) ? (PW+1)'(active_i) : (PW+1)'(MaxIds);
  assign tol_s = $signed({2'b00, tol_i});
  assign d_ab = $signed({ka_rd[KeyW-1], ka_rd}) - $signed({kb_rd[KeyW-1], kb_rd});
  assign d_ma = $signed({mkey_q[KeyW-1], mkey_q}) - $signed({ka_rd[KeyW-1], ka_rd});
  assign d_mb = $signed({mkey_q[KeyW-1], mkey_q}) - $signed({kb_rd[KeyW-1], kb_rd});

  always_ff @(posedge clk_i) begin
    sa_rd <= slots[sra];
    sb_rd <= slots[srb];
    bp_rd <= bptr[bra];
    ka_rd <= keys[kra];
    kb_rd <= keys[krb];
    if (sw_en)  slots[sw_a] <= sw_d;
    if (sw2_en) slots[sw2_a] <= sw2_d;
    if (bw_en)  bptr[bw_a] <= bw_d;
    if (bw2_en) bptr[bw2_a] <= bw2_d;
    if (kw_en)  keys[kw_a] <= c_q.key;
  end

  logic [PW-1:0] last, par_w, lft_w;
  logic [PW:0] rgt;
  logic go_r, stop_up, stop_dn;
  assign last = PW'(cnt_q - CW'(1));
  assign par_w = (pos_q - PW'(1)) >> 1;
  assign lft_w = PW'({pos_q, 1'b1});
  assign rgt  = {1'b0, lft_q} + (PW+1)'(1);
  assign go_r = (rgt < (PW+1)'(cnt_q)) && (d_ab > tol_s);
  assign stop_up = d_ab > tol_s;
  assign stop_dn = go_r ? (d_mb < -tol_s) : (d_ma < -tol_s);

  always_comb begin
    sra = pos_q; srb = last;
    kra = ida_q; krb = idb_q;
    bra = PW'(c_q.item_id);
    bw_en = 1'b0; bw_a = '0; bw_d = '0;
    bw2_en = 1'b0; bw2_a = '0; bw2_d = '0;
    sw_en = 1'b0; sw_a = '0; sw_d = '0;
    sw2_en = 1'b0; sw2_a = '0; sw2_d = '0;
    kw_en = 1'b0; kw_a = PW'(c_q.item_id);
    case (st_q)
      S_CLR: begin
        bw_en = 1'b1; bw_a = clr_q; bw_d = '1;
      end
      S_IDLE: begin
        bra = PW'(cmd_i.item_id);
      end
      S_DEC: begin
        sra = (c_q.kind == KIND_REMOVE) ? PW'(c_q.position) : '0;
        if ((c_q.kind == KIND_INSERT || c_q.kind == KIND_UPDATE) &&
            ({1'b0, c_q.item_id} < limit)) begin
          if (!bp_rd[PW] || c_q.kind == KIND_UPDATE) begin
            kw_en = 1'b1;
          end else if (cnt_q < CW'(MaxIds)) begin
            kw_en = 1'b1;
            sw_en = 1'b1; sw_a = PW'(cnt_q); sw_d = PW'(c_q.item_id);
            bw_en = 1'b1; bw_a = PW'(c_q.item_id); bw_d = (PW+1)'(cnt_q);
          end
        end
      end
      S_TAKE2: begin
        sw_en = 1'b1; sw_a = pos_q; sw_d = sb_rd;
        bw_en = 1'b1; bw_a = sb_rd; bw_d = {1'b0, pos_q};
        bw2_en = 1'b1; bw2_a = sa_rd; bw2_d = '1;
      end
      S_UPRD: begin
        srb = par_w;
      end
      S_UPK: begin
        kra = sa_rd; krb = sb_rd;
      end
      S_UPCMP: begin
        if (!stop_up) begin
          sw_en = 1'b1; sw_a = pos_q; sw_d = idb_q;
          sw2_en = 1'b1; sw2_a = par_q; sw2_d = ida_q;
          bw_en = 1'b1; bw_a = idb_q; bw_d = {1'b0, pos_q};
          bw2_en = 1'b1; bw2_a = ida_q; bw2_d = {1'b0, par_q};
        end
      end
      S_DNRD: begin
        sra = lft_w; srb = lft_w + PW'(1);
      end
      S_DNK: begin
        kra = sa_rd; krb = sb_rd;
      end
      S_DNCMP: begin
        if (!stop_dn) begin
          sw_en = 1'b1; sw_a = pos_q; sw_d = go_r ? idc_q : idb_q;
          sw2_en = 1'b1; sw2_a = go_r ? PW'(rgt) : lft_q; sw2_d = ida_q;
          bw_en = 1'b1; bw_a = go_r ? idc_q : idb_q; bw_d = {1'b0, pos_q};
          bw2_en = 1'b1; bw2_a = ida_q; bw2_d = go_r ? rgt : {1'b0, lft_q};
        end
      end
      S_KEYRD: begin
        kra = (c_q.kind == KIND_PEEK) ? sa_rd : rid_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; clr_q <= '0; cnt_q <= '0; done_o <= 1'b0;
      stat_q <= ST_OK; got_q <= 1'b0; updn_q <= 1'b0;
      pos_q <= '0; par_q <= '0; lft_q <= '0;
      ida_q <= '0; idb_q <= '0; idc_q <= '0; rid_q <= '0; mkey_q <= '0;
    end else begin
      done_o <= 1'b0;
      case (st_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == PW'(MaxIds - 1)) st_q <= S_IDLE;
        end
        S_IDLE: if (avail_i) st_q <= S_DEC;
        S_DEC: begin
          stat_q <= ST_OK; got_q <= 1'b0; updn_q <= 1'b0;
          st_q <= S_OUT;
          if (c_q.kind == KIND_INSERT || c_q.kind == KIND_UPDATE) begin
            if ({1'b0, c_q.item_id} >= limit) stat_q <= ST_ID;
            else if (!bp_rd[PW]) begin
              pos_q <= bp_rd[PW-1:0]; st_q <= S_UPRD;
            end else if (c_q.kind == KIND_INSERT) begin
              if (cnt_q >= CW'(MaxIds)) stat_q <= ST_FULL;
              else begin
                pos_q <= PW'(cnt_q); cnt_q <= cnt_q + 1'b1; st_q <= S_UPRD;
              end
            end
          end else if (c_q.kind == KIND_POP || c_q.kind == KIND_REMOVE ||
                       c_q.kind == KIND_PEEK) begin
            if (cnt_q == '0) stat_q <= ST_EMPTY;
            else if (c_q.kind == KIND_REMOVE && CW'(c_q.position) >= cnt_q)
              stat_q <= ST_POS;
            else begin
              got_q <= 1'b1;
              pos_q <= (c_q.kind == KIND_REMOVE) ? PW'(c_q.position) : '0;
              st_q <= (c_q.kind == KIND_PEEK) ? S_KEYRD : S_TAKE;
            end
          end
        end
        S_TAKE: st_q <= S_TAKE2;
        S_TAKE2: begin
          rid_q <= sa_rd;
          ida_q <= sb_rd;
          cnt_q <= cnt_q - 1'b1;
          updn_q <= 1'b1;
          if (CW'(pos_q) < cnt_q - 1'b1) st_q <= S_UPRD;
          else st_q <= S_KEYRD;
        end
        S_UPRD: begin
          par_q <= par_w;
          if (pos_q == '0 || CW'(pos_q) >= cnt_q)
            st_q <= updn_q ? S_DNRD : (got_q ? S_KEYRD : S_OUT);
          else st_q <= S_UPK;
        end
        S_UPK: begin
          ida_q <= sa_rd; idb_q <= sb_rd; st_q <= S_UPCMP;
        end
        S_UPCMP: begin
          if (stop_up)
            st_q <= updn_q ? S_DNRD : (got_q ? S_KEYRD : S_OUT);
          else begin
            pos_q <= par_q; updn_q <= 1'b0; st_q <= S_UPRD;
          end
        end
        S_DNRD: begin
          lft_q <= lft_w;
          if (CW'(pos_q) < (cnt_q >> 1)) st_q <= S_DNK;
          else st_q <= got_q ? S_KEYRD : S_OUT;
        end
        S_DNK: begin
          mkey_q <= ka_rd;
          idb_q <= sa_rd; idc_q <= sb_rd; st_q <= S_DNCMP;
        end
        S_DNCMP: begin
          if (stop_dn) st_q <= S_KEYRD;
          else begin
            pos_q <= go_r ? PW'(rgt) : lft_q; st_q <= S_DNRD;
          end
        end
        S_KEYRD: begin
          if (c_q.kind == KIND_PEEK) rid_q <= sa_rd;
          st_q <= S_OUT;
        end
        S_OUT: begin
          done_o <= 1'b1; st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && avail_i) c_q <= cmd_i;
    if (st_q == S_OUT) begin
      res_o.result_id  <= got_q ? 10'(rid_q) : '0;
      res_o.result_key <= got_q ? ka_rd : '0;
      res_o.heap_size  <= 11'(cnt_q);
      res_o.status     <= stat_q;
    end
  end

  assign pop_o = st_q == S_IDLE && avail_i;
  assign clr_busy_o = st_q == S_CLR;
endmodule
`default_nettype wire

// ===== rtl/core/indexed_min_heap_queue_top.sv =====
// One command in, one result out. Each command yields exactly one result strobe
// (done_o) when it completes; a sift takes longer the more heap levels it walks.
// The back-pointer memory is cleared entry by entry after reset; busy is high
// meanwhile. A two-entry command queue sits in front; busy rises when it is
// full. Results cannot be stalled by the receiver.
`default_nettype none
module indexed_min_heap_queue_top import imhq_pkg::*; #(
  parameter int unsigned MAX_IDS = MaxIdsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire cmd_t cmd_i,
  output logic      done_o,
  output res_t      res_o,
  input  wire logic cfg_we_i,
  input  wire logic [0:0] cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_data_i
);
  logic [TolW-1:0] tol_q;
  logic [10:0] act_q;
  logic full, avail, pop, clr_busy;
  cmd_t qcmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0; act_q <= 11'd1024;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_TOL) tol_q <= cfg_data_i[TolW-1:0];
      else act_q <= cfg_data_i[10:0];
    end
  end

  assign busy = full || clr_busy;

  imhq_front u_front (
    .clk_i, .rst_ni, .push_i(start && !busy), .cmd_i,
    .pop_i(pop), .full_o(full), .avail_o(avail), .cmd_o(qcmd)
  );

  imhq_back #(.MaxIds(MAX_IDS)) u_back (
    .clk_i, .rst_ni, .tol_i(tol_q), .active_i(act_q), .avail_i(avail),
    .cmd_i(qcmd), .pop_o(pop), .clr_busy_o(clr_busy), .done_o, .res_o
  );
endmodule
`default_nettype wire
